/* rtl/core/scc_pair_counter_assert.svh */
// Assertion macros for the pair counter checker
`ifndef SCC_PAIR_COUNTER_ASSERT_SVH
`define SCC_PAIR_COUNTER_ASSERT_SVH

// Next-cycle implication, ignored while reset is asserted
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define SCC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/scc_pkg.sv */
// Shared types and constants for the SCC pair counter
`timescale 1ns / 1ps
package scc_pkg;

  localparam int WORD_BITS = 64;
  localparam int OFF_BITS  = 6;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FLIP  = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  localparam int         NODE_COUNT_W   = 9;
  localparam logic [8:0] NODE_COUNT_RST = 9'd256;

  localparam int          PAIR_W   = 15;
  localparam logic [14:0] PAIR_MAX = 15'h7FFF;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic cnt_init;
    logic sel_edit;
    logic edit_wr;
    logic outer_sel;
    logic use_adj;
    logic walk_start;
    logic push;
    logic outer_adv;
    logic scan_adv;
    logic finish;
    logic pop_load;
    logic order_rd;
    logic order_load;
    logic pass2_init;
    logic mul;
    logic acc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic       found;
    logic       hit;
    logic       more;
    logic       sp_zero;
    logic       top_zero;
    logic       pass;
    logic       clr_last;
    logic       out_free;
    logic       idx_ok;
    logic [1:0] mode;
  } sts_t;

  // Lowest set bit; msb flags that any bit was set
  function automatic logic [OFF_BITS:0] first_set(input word_t w);
    logic [OFF_BITS:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = {1'b1, OFF_BITS'(i)};
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/scc_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module scc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/scc_ctrl.sv */
// Sequencer for edits, clearing and the two depth-first passes
`timescale 1ns / 1ps
module scc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  scc_pkg::sts_t sts,
  output scc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EDIT_RD, ST_EDIT_WR, ST_INIT, ST_P1_RD, ST_P1_CHK,
    ST_W_RD, ST_W_CHK, ST_W_POP, ST_P2_NEXT, ST_P2_WAIT, ST_P2_CHK,
    ST_SUM_MUL, ST_SUM_ADD, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   in_accept;

  assign in_stall  = in_stall_r;
  assign in_accept = in_valid && !in_stall_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.capture = in_accept;
        if (in_accept) begin
          if (sts.mode == scc_pkg::MODE_COUNT) begin
            state_nxt = ST_INIT;
          end else if ((sts.mode == scc_pkg::MODE_WRITE || sts.mode == scc_pkg::MODE_FLIP)
                       && sts.idx_ok) begin
            state_nxt = ST_EDIT_RD;
          end
        end
      end
      ST_EDIT_RD: begin
        cmd.sel_edit = 1'b1;
        state_nxt    = ST_EDIT_WR;
      end
      ST_EDIT_WR: begin
        cmd.sel_edit = 1'b1;
        cmd.edit_wr  = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_INIT: begin
        cmd.cnt_init = 1'b1;
        state_nxt    = ST_P1_RD;
      end
      ST_P1_RD: begin
        cmd.outer_sel = 1'b1;
        state_nxt     = ST_P1_CHK;
      end
      ST_P1_CHK: begin
        cmd.outer_sel = 1'b1;
        if (sts.found) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_W_RD;
        end else if (sts.more) begin
          cmd.outer_adv = 1'b1;
          state_nxt     = ST_P1_RD;
        end else begin
          cmd.pass2_init = 1'b1;
          state_nxt      = ST_P2_NEXT;
        end
      end
      ST_W_RD: begin
        cmd.use_adj = 1'b1;
        state_nxt   = ST_W_CHK;
      end
      ST_W_CHK: begin
        cmd.use_adj = 1'b1;
        if (sts.found) begin
          cmd.push  = 1'b1;
          state_nxt = ST_W_RD;
        end else if (sts.more) begin
          cmd.scan_adv = 1'b1;
          state_nxt    = ST_W_RD;
        end else begin
          cmd.finish = 1'b1;
          if (!sts.sp_zero) begin
            state_nxt = ST_W_POP;
          end else if (sts.pass) begin
            state_nxt = ST_SUM_MUL;
          end else begin
            state_nxt = ST_P1_RD;
          end
        end
      end
      ST_W_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = ST_W_RD;
      end
      ST_P2_NEXT: begin
        if (sts.top_zero) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.order_rd = 1'b1;
          state_nxt    = ST_P2_WAIT;
        end
      end
      ST_P2_WAIT: begin
        cmd.order_load = 1'b1;
        state_nxt      = ST_P2_CHK;
      end
      ST_P2_CHK: begin
        if (sts.found && sts.hit) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_W_RD;
        end else begin
          state_nxt = ST_P2_NEXT;
        end
      end
      ST_SUM_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM_ADD;
      end
      ST_SUM_ADD: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_P2_NEXT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

endmodule

/* rtl/core/scc_dp.sv */
// Datapath: adjacency RAMs, visited marks, walk stack, finish order, sum
`timescale 1ns / 1ps
module scc_dp #(
  parameter int MAX_NODES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scc_pkg::cmd_t cmd,
  output scc_pkg::sts_t sts,
  input  logic [1:0]    in_mode,
  input  logic [7:0]    in_from_node,
  input  logic [7:0]    in_to_node,
  input  logic          in_edge_value,
  input  logic          cfg_write_en,
  input  logic [8:0]    cfg_write_data,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [14:0]   out_pair_count
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int NC    = NW + 1;
  localparam int RW    = (MAX_NODES + 63) / 64;
  localparam int DEPTH = MAX_NODES * RW;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (NC > 7) ? NC : 7;
  localparam int WDW   = PW - 6;
  localparam int VIW   = (RW > 1) ? $clog2(RW) : 1;
  localparam int SW    = NW + NC;
  localparam int SUMW  = 2 * NC;
  localparam int CMPW  = (NC > 9) ? NC : 9;

  // configuration and edit capture
  logic [8:0]    ncfg_r;
  logic [NC-1:0] n_r;
  logic [1:0]    ed_mode_r;
  logic [NW-1:0] ed_a_r, ed_b_r;
  logic          ed_val_r;

  // walk state
  logic [AW-1:0]       clr_addr_r;
  scc_pkg::word_t      vis_r [RW];
  logic [NW-1:0]       cur_u_r;
  logic [NC-1:0]       cur_v_r, outer_r, sp_r, top_r, cnt_r;
  logic                pass_r;
  logic [SUMW-1:0]     prod_r, sum_r;
  logic                out_valid_r;
  logic [14:0]         pair_r;

  // scan window
  logic [NC-1:0]          scan_pos;
  logic [PW-1:0]          pos_p, base, f_full;
  logic [WDW-1:0]         pword;
  logic [5:0]             poff;
  logic [PW:0]            base_x, n_x, next_x, diff;
  scc_pkg::word_t         vis_word, lt_mask, ge_mask, adj_word, cand;
  logic [6:0]             fs;
  logic [NW-1:0]          f_node;
  logic [NC-1:0]          next_pos, f_plus1, n_eff;

  // RAM ports
  logic [AW-1:0]       walk_addr, fwd_ed_addr, rev_ed_addr, fwd_ra, rev_ra, adj_wa_f, adj_wa_r;
  scc_pkg::word_t      fwd_rd, rev_rd, fwd_wd, rev_wd;
  logic                adj_we, new_bit;
  logic [PW-1:0]       a_p, b_p;
  logic [NC-1:0]       sp_m1, top_m1;
  logic [SW-1:0]       stk_rd;
  logic [NW-1:0]       ord_rd;
  logic                ord_we;

  function automatic logic [AW-1:0] row_addr(input logic [NW-1:0] r, input logic [WDW-1:0] w);
    return AW'(AW'(r) * AW'(RW) + AW'(w));
  endfunction

  assign n_eff = (CMPW'(ncfg_r) > CMPW'(MAX_NODES)) ? NC'(MAX_NODES) : NC'(ncfg_r);

  assign scan_pos = cmd.outer_sel ? outer_r : cur_v_r;
  assign pos_p    = PW'(scan_pos);
  assign pword    = pos_p[PW-1:6];
  assign poff     = pos_p[5:0];
  assign base     = {pword, 6'b0};
  assign base_x   = (PW+1)'(base);
  assign n_x      = (PW+1)'(n_r);
  assign next_x   = base_x + (PW+1)'(64);
  assign diff     = n_x - base_x;
  assign next_pos = NC'(next_x);

  assign vis_word = (32'(pword) < RW) ? vis_r[VIW'(pword)] : '1;

  always_comb begin
    if (n_x <= base_x) begin
      lt_mask = '0;
    end else if (diff >= (PW+1)'(64)) begin
      lt_mask = '1;
    end else begin
      lt_mask = (scc_pkg::word_t'(1) << diff[5:0]) - scc_pkg::word_t'(1);
    end
  end

  assign ge_mask  = '1 << poff;
  assign adj_word = pass_r ? rev_rd : fwd_rd;
  assign cand     = (cmd.use_adj ? adj_word : '1) & ~vis_word & ge_mask & lt_mask;
  assign fs       = scc_pkg::first_set(cand);
  assign f_full   = {pword, fs[5:0]};
  assign f_node   = NW'(f_full);
  assign f_plus1  = NC'(f_node) + NC'(1);

  // adjacency addressing: forward row a holds bit b, reverse row b holds bit a
  assign a_p         = PW'(ed_a_r);
  assign b_p         = PW'(ed_b_r);
  assign fwd_ed_addr = row_addr(ed_a_r, b_p[PW-1:6]);
  assign rev_ed_addr = row_addr(ed_b_r, a_p[PW-1:6]);
  assign walk_addr   = row_addr(cur_u_r, pword);
  assign fwd_ra      = cmd.sel_edit ? fwd_ed_addr : walk_addr;
  assign rev_ra      = cmd.sel_edit ? rev_ed_addr : walk_addr;

  assign new_bit  = (ed_mode_r == scc_pkg::MODE_FLIP) ? ~fwd_rd[b_p[5:0]] : ed_val_r;
  assign adj_we   = cmd.clr_step | cmd.edit_wr;
  assign adj_wa_f = cmd.clr_step ? clr_addr_r : fwd_ed_addr;
  assign adj_wa_r = cmd.clr_step ? clr_addr_r : rev_ed_addr;
  assign fwd_wd   = cmd.clr_step ? '0 :
                    ((fwd_rd & ~(scc_pkg::word_t'(1) << b_p[5:0]))
                     | (scc_pkg::word_t'(new_bit) << b_p[5:0]));
  assign rev_wd   = cmd.clr_step ? '0 :
                    ((rev_rd & ~(scc_pkg::word_t'(1) << a_p[5:0]))
                     | (scc_pkg::word_t'(new_bit) << a_p[5:0]));

  scc_ram #(.WIDTH(scc_pkg::WORD_BITS), .DEPTH(DEPTH)) u_fwd (
    .clk(clk), .we(adj_we), .waddr(adj_wa_f), .wdata(fwd_wd), .raddr(fwd_ra), .rdata(fwd_rd)
  );

  scc_ram #(.WIDTH(scc_pkg::WORD_BITS), .DEPTH(DEPTH)) u_rev (
    .clk(clk), .we(adj_we), .waddr(adj_wa_r), .wdata(rev_wd), .raddr(rev_ra), .rdata(rev_rd)
  );

  // walk stack holds suspended (node, resume position) pairs; top lives in cur_*
  assign sp_m1 = sp_r - NC'(1);

  scc_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stack (
    .clk(clk), .we(cmd.push), .waddr(sp_r[NW-1:0]), .wdata({cur_u_r, f_plus1}),
    .raddr(sp_m1[NW-1:0]), .rdata(stk_rd)
  );

  assign top_m1 = top_r - NC'(1);
  assign ord_we = cmd.finish && !pass_r && (32'(top_r) < MAX_NODES);

  scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_order (
    .clk(clk), .we(ord_we), .waddr(top_r[NW-1:0]), .wdata(cur_u_r),
    .raddr(top_m1[NW-1:0]), .rdata(ord_rd)
  );

  assign sts.found    = fs[6];
  assign sts.hit      = (f_node == cur_u_r);
  assign sts.more     = (next_x < n_x);
  assign sts.sp_zero  = (sp_r == '0);
  assign sts.top_zero = (top_r == '0);
  assign sts.pass     = pass_r;
  assign sts.clr_last = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.idx_ok   = (32'(in_from_node) < MAX_NODES) && (32'(in_to_node) < MAX_NODES);
  assign sts.mode     = in_mode;

  assign out_valid      = out_valid_r;
  assign out_pair_count = pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      ncfg_r      <= scc_pkg::NODE_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_write_en) ncfg_r <= cfg_write_data;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ed_mode_r <= in_mode;
      ed_a_r    <= NW'(in_from_node);
      ed_b_r    <= NW'(in_to_node);
      ed_val_r  <= in_edge_value;
    end
    if (cmd.cnt_init) begin
      n_r     <= n_eff;
      pass_r  <= 1'b0;
      top_r   <= '0;
      outer_r <= '0;
      sum_r   <= '0;
      for (int k = 0; k < RW; k++) vis_r[k] <= '0;
    end
    if (cmd.pass2_init) begin
      pass_r <= 1'b1;
      for (int k = 0; k < RW; k++) vis_r[k] <= '0;
    end
    if (cmd.walk_start) begin
      vis_r[VIW'(pword)][fs[5:0]] <= 1'b1;
      cur_u_r <= f_node;
      cur_v_r <= '0;
      sp_r    <= '0;
      cnt_r   <= NC'(1);
      outer_r <= f_plus1;
    end
    if (cmd.push) begin
      vis_r[VIW'(pword)][fs[5:0]] <= 1'b1;
      cur_u_r <= f_node;
      cur_v_r <= '0;
      sp_r    <= sp_r + NC'(1);
      cnt_r   <= cnt_r + NC'(1);
    end
    if (cmd.outer_adv) outer_r <= next_pos;
    if (cmd.scan_adv) cur_v_r <= next_pos;
    if (cmd.finish) begin
      if (ord_we) top_r <= top_r + NC'(1);
      if (sp_r != '0) sp_r <= sp_m1;
    end
    if (cmd.pop_load) begin
      cur_u_r <= stk_rd[SW-1:NC];
      cur_v_r <= stk_rd[NC-1:0];
    end
    if (cmd.order_rd) top_r <= top_m1;
    if (cmd.order_load) begin
      cur_u_r <= ord_rd;
      cur_v_r <= NC'(ord_rd);
    end
    if (cmd.mul) prod_r <= SUMW'(cnt_r) * SUMW'(cnt_r - NC'(1));
    if (cmd.acc) sum_r <= sum_r + (prod_r >> 1);
    if (cmd.load_out) begin
      pair_r <= (32'(sum_r) > 32'(scc_pkg::PAIR_MAX)) ? scc_pkg::PAIR_MAX : 15'(sum_r);
    end
  end

endmodule

/* rtl/core/scc_pair_counter.sv */
// Top level: strongly connected component pair counter
// Edits (write or flip one edge) pass through a read state and a write
// state; unused modes are taken and dropped. Every adjacency word read in
// a count goes through the registered read port of the edge RAMs.
// One request is worked at a time; the result waits in an output register.
// Reset is synchronous, active low, and starts a clearing pass over every
// word of the edge RAMs with in_stall high.
`timescale 1ns / 1ps
module scc_pair_counter #(
  parameter int MAX_NODES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_from_node,
  input  logic [7:0]  in_to_node,
  input  logic        in_edge_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_pair_count,
  input  logic        cfg_write_en,
  input  logic [8:0]  cfg_write_data
);

  // Controller steps the two depth-first passes; the datapath owns all storage.
  scc_pkg::cmd_t cmd;
  scc_pkg::sts_t sts;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Pass one records finish order; pass two walks the reverse matrix from
  // the most recently finished node and sums size*(size-1)/2 per tree.
  scc_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_from_node   (in_from_node),
    .in_to_node     (in_to_node),
    .in_edge_value  (in_edge_value),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_pair_count (out_pair_count)
  );

endmodule

/* rtl/core/scc_chk.sv */
// Port-level checker for the pair counter and its bind
`timescale 1ns / 1ps
`include "scc_pair_counter_assert.svh"
module scc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [14:0] out_pair_count
);

  `SCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `SCC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_pair_count), "result changed while stalled")
  `SCC_ASSERT_NEXT(a_count_busy, in_valid && !in_stall && in_mode == scc_pkg::MODE_COUNT, in_stall, "count request did not make block busy")
  `SCC_ASSERT_ALWAYS(a_rst_busy, !rst_n, in_stall, "requests taken during clearing pass")

endmodule

bind scc_pair_counter scc_chk u_scc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pair_count (out_pair_count)
);
